[src/assert_macros.svh]
// Assertion macros used by the top level of the plant step block.
// No dependencies; expects clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check post in the same cycle as pre.
`define ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Check post in the cycle after pre.
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[src/dap_pkg.sv]
// Package for the damped axis plant step: widths, register map, command types.
// No dependencies.
package dap_pkg;

    localparam int AXIS_W      = 3;
    localparam int DATA_W      = 32;
    localparam int DT_W        = 16;
    localparam int NUM_FORCES  = 6;
    localparam int IN_TDATA_W  = DT_W + NUM_FORCES * DATA_W;
    localparam int OUT_FIELD_W = AXIS_W + 3 * DATA_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int DAMP_W      = 16;
    localparam int THR_W       = 31;
    localparam int INVM_W      = 25;
    localparam int OPA_W       = 34;
    localparam int OPB_W       = 26;
    localparam int PROD_W      = OPA_W + OPB_W;
    localparam int FRAC_W      = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_AXES     = 3'd0,
        CFG_DAMPING      = 3'd1,
        CFG_STICTION     = 3'd2,
        CFG_ACCEL_LIMIT  = 3'd3,
        CFG_REST_SPEED   = 3'd4,
        CFG_INVERSE_MASS = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [AXIS_W-1:0] num_axes;
        logic [DAMP_W-1:0] damping;
        logic [THR_W-1:0]  stiction;
        logic [THR_W-1:0]  accel_limit;
        logic [THR_W-1:0]  rest_speed;
        logic [INVM_W-1:0] inverse_mass;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        num_axes:     3'd6,
        damping:      16'd6554,
        stiction:     31'd19661,
        accel_limit:  31'd655360,
        rest_speed:   31'd655,
        inverse_mass: 25'd65536
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_LOAD,
        ST_MUL_DAMP,
        ST_FNET,
        ST_MUL_MASS,
        ST_CLAMP,
        ST_MUL_ACC,
        ST_VEL,
        ST_MUL_POS,
        ST_COMMIT,
        ST_EMIT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_TAKE,
        OP_LOAD,
        OP_MUL,
        OP_FNET,
        OP_CLAMP,
        OP_VEL,
        OP_COMMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   emit;
    } dp_cmd_t;

    typedef struct packed {
        logic dt_zero;
        logic n_zero;
        logic last;
        logic out_free;
    } dp_sts_t;

endpackage

[src/dap_cfg.sv]
// Configuration register file of the plant step block.
// Depends on dap_pkg.
module dap_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dap_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dap_pkg::CFG_DATA_W-1:0] cfg_data,
    output dap_pkg::cfg_t                  cfg
);
    import dap_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_NUM_AXES:     cfg_next.num_axes     = cfg_data[AXIS_W-1:0];
                CFG_DAMPING:      cfg_next.damping      = cfg_data[DAMP_W-1:0];
                CFG_STICTION:     cfg_next.stiction     = cfg_data[THR_W-1:0];
                CFG_ACCEL_LIMIT:  cfg_next.accel_limit  = cfg_data[THR_W-1:0];
                CFG_REST_SPEED:   cfg_next.rest_speed   = cfg_data[THR_W-1:0];
                CFG_INVERSE_MASS: cfg_next.inverse_mass = cfg_data[INVM_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[src/dap_ctrl.sv]
// Sequencer of the plant step block: steps the datapath through each axis.
// Depends on dap_pkg.
module dap_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  dap_pkg::dp_sts_t sts,
    output dap_pkg::dp_cmd_t cmd
);
    import dap_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sts.n_zero ? ST_IDLE : ST_START;
                end
            end
            ST_START:    state_next = sts.dt_zero ? ST_EMIT : ST_LOAD;
            ST_LOAD:     state_next = ST_MUL_DAMP;
            ST_MUL_DAMP: state_next = ST_FNET;
            ST_FNET:     state_next = ST_MUL_MASS;
            ST_MUL_MASS: state_next = ST_CLAMP;
            ST_CLAMP:    state_next = ST_MUL_ACC;
            ST_MUL_ACC:  state_next = ST_VEL;
            ST_VEL:      state_next = ST_MUL_POS;
            ST_MUL_POS:  state_next = ST_COMMIT;
            ST_COMMIT:   state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.last ? ST_IDLE : ST_START;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd.op   = OP_NONE;
        cmd.emit = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.op   = in_valid ? OP_TAKE : OP_NONE;
            end
            ST_LOAD:     cmd.op = OP_LOAD;
            ST_MUL_DAMP: cmd.op = OP_MUL;
            ST_FNET:     cmd.op = OP_FNET;
            ST_MUL_MASS: cmd.op = OP_MUL;
            ST_CLAMP:    cmd.op = OP_CLAMP;
            ST_MUL_ACC:  cmd.op = OP_MUL;
            ST_VEL:      cmd.op = OP_VEL;
            ST_MUL_POS:  cmd.op = OP_MUL;
            ST_COMMIT:   cmd.op = OP_COMMIT;
            ST_EMIT:     cmd.emit = sts.out_free;
            default:     cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[src/dap_dp.sv]
// Datapath of the plant step block: axis state, shared multiplier, result register.
// Depends on dap_pkg.
module dap_dp #(
    parameter int MAX_AXES = 6
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  dap_pkg::cfg_t                   cfg,
    input  dap_pkg::dp_cmd_t                cmd,
    output dap_pkg::dp_sts_t                sts,
    input  logic [dap_pkg::IN_TDATA_W-1:0]  in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [dap_pkg::OUT_TDATA_W-1:0] out_data,
    output logic                            out_last
);
    import dap_pkg::*;

    localparam int IDX_W = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [DATA_W+1:0] x);
        logic signed [DATA_W-1:0] r;
        r = x[DATA_W-1:0];
        if (!x[DATA_W+1] && (|x[DATA_W:DATA_W-1]))
        begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end
        else if (x[DATA_W+1] && !(&x[DATA_W:DATA_W-1]))
        begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end
        return r;
    endfunction

    logic [DT_W-1:0]               dt_reg;
    logic signed [DATA_W-1:0]      force_reg [NUM_FORCES];
    logic [AXIS_W-1:0]             axis_reg;
    logic signed [DATA_W-1:0]      pos_reg [MAX_AXES];
    logic signed [DATA_W-1:0]      vel_reg [MAX_AXES];
    logic signed [DATA_W-1:0]      acc_reg [MAX_AXES];
    logic signed [DATA_W-1:0]      f_eff_reg;
    logic signed [DATA_W-1:0]      v_eff_reg;
    logic signed [DATA_W-1:0]      p_reg;
    logic signed [DATA_W-1:0]      a_reg;
    logic signed [DATA_W-1:0]      vn_reg;
    logic signed [OPA_W-1:0]       op_a_reg;
    logic signed [OPB_W-1:0]       op_b_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic                          out_valid_reg;
    logic                          out_last_reg;
    logic [OUT_FIELD_W-1:0]        out_field_reg;

    logic [IDX_W-1:0]              idx;
    logic [AXIS_W-1:0]             n_eff;
    logic signed [DATA_W-1:0]      force_sel;
    logic signed [DATA_W-1:0]      v_cur;
    logic [DATA_W-1:0]             f_mag;
    logic [DATA_W-1:0]             v_mag;
    logic                          resting;
    logic signed [DATA_W-1:0]      f_load;
    logic signed [DATA_W-1:0]      v_load;
    logic signed [DATA_W:0]        prod_q33;
    logic signed [OPA_W-1:0]       fnet;
    logic signed [PROD_W-FRAC_W-1:0] mass_q;
    logic signed [PROD_W-FRAC_W-1:0] lim_pos;
    logic signed [PROD_W-FRAC_W-1:0] lim_neg;
    logic signed [DATA_W-1:0]      a_clamp;
    logic signed [DATA_W+1:0]      v_sum;
    logic signed [DATA_W+1:0]      p_sum;
    logic signed [DATA_W-1:0]      vn;
    logic signed [DATA_W-1:0]      pn;

    assign idx   = IDX_W'(axis_reg);
    assign n_eff = (32'(cfg.num_axes) > MAX_AXES) ? AXIS_W'(MAX_AXES) : cfg.num_axes;

    assign sts.n_zero   = (n_eff == '0);
    assign sts.dt_zero  = (dt_reg == '0);
    assign sts.last     = ({1'b0, axis_reg} + (AXIS_W+1)'(1)) == {1'b0, n_eff};
    assign sts.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        force_sel = '0;
        if (32'(axis_reg) < NUM_FORCES)
        begin
            force_sel = force_reg[axis_reg];
        end
    end

    assign v_cur   = vel_reg[idx];
    assign f_mag   = force_sel[DATA_W-1] ? (~force_sel + DATA_W'(1)) : force_sel;
    assign v_mag   = v_cur[DATA_W-1] ? (~v_cur + DATA_W'(1)) : v_cur;
    assign resting = (v_mag < {1'b0, cfg.rest_speed}) && (f_mag < {1'b0, cfg.stiction});
    assign f_load  = resting ? '0 : force_sel;
    assign v_load  = resting ? '0 : v_cur;

    assign prod_q33 = prod_reg[DATA_W+FRAC_W:FRAC_W];
    assign fnet     = {{2{f_eff_reg[DATA_W-1]}}, f_eff_reg} - {prod_q33[DATA_W], prod_q33};
    assign mass_q   = prod_reg[PROD_W-1:FRAC_W];
    assign lim_pos  = {{(PROD_W-FRAC_W-THR_W){1'b0}}, cfg.accel_limit};
    assign lim_neg  = -lim_pos;

    always_comb
    begin
        a_clamp = mass_q[DATA_W-1:0];
        if (mass_q > lim_pos)
        begin
            a_clamp = lim_pos[DATA_W-1:0];
        end
        else if (mass_q < lim_neg)
        begin
            a_clamp = lim_neg[DATA_W-1:0];
        end
    end

    assign v_sum = {{2{v_eff_reg[DATA_W-1]}}, v_eff_reg} + {prod_q33[DATA_W], prod_q33};
    assign p_sum = {{2{p_reg[DATA_W-1]}}, p_reg} + {prod_q33[DATA_W], prod_q33};
    assign vn    = sat32(v_sum);
    assign pn    = sat32(p_sum);

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_TAKE:
            begin
                dt_reg <= in_data[DT_W-1:0];
                for (int i = 0; i < NUM_FORCES; i++)
                begin
                    force_reg[i] <= in_data[DT_W+i*DATA_W +: DATA_W];
                end
            end
            OP_LOAD:
            begin
                f_eff_reg <= f_load;
                v_eff_reg <= v_load;
                p_reg     <= pos_reg[idx];
                op_a_reg  <= {{2{v_load[DATA_W-1]}}, v_load};
                op_b_reg  <= {{(OPB_W-DAMP_W){1'b0}}, cfg.damping};
            end
            OP_MUL:
            begin
                prod_reg <= PROD_W'(op_a_reg) * PROD_W'(op_b_reg);
            end
            OP_FNET:
            begin
                op_a_reg <= fnet;
                op_b_reg <= {{(OPB_W-INVM_W){1'b0}}, cfg.inverse_mass};
            end
            OP_CLAMP:
            begin
                a_reg    <= a_clamp;
                op_a_reg <= {{2{a_clamp[DATA_W-1]}}, a_clamp};
                op_b_reg <= {{(OPB_W-DT_W){1'b0}}, dt_reg};
            end
            OP_VEL:
            begin
                vn_reg   <= vn;
                op_a_reg <= {{2{vn[DATA_W-1]}}, vn};
                op_b_reg <= {{(OPB_W-DT_W){1'b0}}, dt_reg};
            end
            default:
            begin
            end
        endcase
        if (cmd.emit)
        begin
            out_field_reg <= {pos_reg[idx], vel_reg[idx], acc_reg[idx], axis_reg};
            out_last_reg  <= sts.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_AXES; i++)
            begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.op == OP_TAKE)
            begin
                axis_reg <= '0;
            end
            else if (cmd.emit)
            begin
                axis_reg <= axis_reg + AXIS_W'(1);
            end
            if (cmd.op == OP_COMMIT)
            begin
                acc_reg[idx] <= a_reg;
                vel_reg[idx] <= vn_reg;
                pos_reg[idx] <= pn;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_last  = out_last_reg;
    assign out_data  = {{(OUT_TDATA_W-OUT_FIELD_W){1'b0}}, out_field_reg};

endmodule

[src/damped_axis_plant_step.sv]
// Damped multi-axis plant step, top level: stream ports, config port, assertions.
// Depends on dap_pkg, dap_cfg, dap_ctrl, dap_dp and assert_macros.svh.
//
// Each request carries dt (Q0.16) and one Q16.16 force per axis; the block advances
// a mass-damper with stiction on every active axis by semi-implicit Euler and returns
// one result per active axis (axis, accel, velocity, position), tlast on the final one.
// Requests are taken while idle and their axes done in turn; with zero dt an axis only
// emits its state, and emits wait while the output side stalls. One shared 34x26
// multiplier forms four dependent products in turn (damping, inverse mass, velocity
// step, position step). The input is ready only between requests; a finished result
// waits in an output register. Axis state resets to zero. The user must make a
// configuration write between requests; the block itself does not enforce this.
`include "assert_macros.svh"

module damped_axis_plant_step #(
    parameter int MAX_AXES = 6
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // dt[15:0], force_0[47:16], force_1[79:48], force_2[111:80],
    // force_3[143:112], force_4[175:144], force_5[207:176]
    input  logic [dap_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // axis[2:0], accel[34:3], velocity[66:35], position[98:67], zero[103:99]
    output logic [dap_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dap_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dap_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import dap_pkg::*;

    cfg_t    cfg;
    dp_cmd_t cmd;
    dp_sts_t sts;

    dap_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dap_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dap_dp #(
        .MAX_AXES (MAX_AXES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

    `ASSERT_IMPL(a_emit_free, cmd.emit, sts.out_free, "result overwrote a pending result")
    `ASSERT_IMPL(a_commit_dt, cmd.op == OP_COMMIT, !sts.dt_zero, "state update with zero dt")
    `ASSERT_NEXT(a_empty_idle, s_axis_tvalid && s_axis_tready && sts.n_zero, s_axis_tready, "empty request did not return to idle")
    `ASSERT_NEXT(a_last_idle, cmd.emit && sts.last, s_axis_tready && m_axis_tvalid && m_axis_tlast, "last result did not end the request")

endmodule
